[hdl/sha256_stream_hasher_core_defines.svh]
// Assertion macros shared by the SHA-256 stream hasher RTL.
// Included by modules that carry concurrent assertions.
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH
// Implication checked on every clock, off during reset.
`define SHA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbl failed");
// Next-cycle implication.
`define SHA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbl failed");
`endif

[hdl/sha_pkg.sv]
// Package for the SHA-256 stream hasher: round constants, initial hash, helpers.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;
	typedef logic [31:0] word_t;

	localparam logic [7:0] PadByte = 8'h80;

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8fc, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	// compression engine handshake
	typedef struct packed {
		logic start;
		logic busy;
	} cmp_ctl_t;

	function automatic word_t rotr(input word_t v, input int unsigned s);
		rotr = (v >> s) | (v << (32 - s));
	endfunction
endpackage

[hdl/sha_round.sv]
// SHA-256 compression engine: one round per cycle over a 16-word window.
// Depends on sha_pkg.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_core_defines.svh"
module sha_round (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  ld_we,
	input  logic [3:0]            ld_slot,
	input  logic [7:0]            ld_byte,
	input  logic                  hash_init,
	output sha_pkg::cmp_ctl_t     ctl,
	output sha_pkg::word_t        hash [8]
);
	sha_pkg::word_t win_q [16];
	sha_pkg::word_t v_q [8];
	sha_pkg::word_t h_q [8];
	logic [5:0] rnd_q;
	logic       busy_q;
	logic       fin_q;

	sha_pkg::word_t a15, a2, s0, s1, wn, w, big1, chs, t1, big0, mj;
	logic [3:0] ix;

	always_comb begin
		ix   = rnd_q[3:0];
		a15  = win_q[ix + 4'd1];
		a2   = win_q[ix + 4'd14];
		s0   = sha_pkg::rotr(a15, 7) ^ sha_pkg::rotr(a15, 18) ^ (a15 >> 3);
		s1   = sha_pkg::rotr(a2, 17) ^ sha_pkg::rotr(a2, 19) ^ (a2 >> 10);
		wn   = win_q[ix] + s0 + win_q[ix + 4'd9] + s1;
		w    = (rnd_q >= 6'd16) ? wn : win_q[ix];
		big1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
			^ sha_pkg::rotr(v_q[4], 25);
		chs  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + big1 + chs + sha_pkg::RoundK[rnd_q] + w;
		big0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
			^ sha_pkg::rotr(v_q[0], 22);
		mj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			win_q[ld_slot] <= {win_q[ld_slot][23:0], ld_byte};
		end else if (busy_q) begin
			win_q[ix] <= w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::InitHash[i];
				v_q[i] <= '0;
			end
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			end else if (busy_q) begin
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + big0 + mj;
				rnd_q  <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end else if (hash_init) begin
				for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q | fin_q;
	always_comb for (int i = 0; i < 8; i++) hash[i] = h_q[i];

	`SHA_ASSERT_IMP(a_no_start_busy, start, !busy_q && !fin_q)
	`SHA_ASSERT_NXT(a_start_busy, start, busy_q && rnd_q == 6'd0)
	`SHA_ASSERT_IMP(a_no_load_busy, ld_we, !busy_q)
	`SHA_ASSERT_NXT(a_end_fin, busy_q && rnd_q == 6'd63, fin_q)
endmodule

[hdl/sha256_stream_hasher_core.sv]
// Top level of the SHA-256 stream hasher: byte intake, padding sequencer, digest out.
// Depends on sha_pkg and sha_round.
// Each accepted byte goes into the round unit's window; a full block starts a
// compression (64 rounds, one per cycle, in the shared round unit, plus feed-forward).
// Intake stalls meanwhile. A last item adds padding, one or two compressions, then 8
// result transfers and a hash reload. Reset (arst_n low) returns to the initial hash.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_core_defines.svh"
module sha256_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_in,
	output logic        ready_in,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        valid_out,
	input  logic        ready_out,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StCmp  = 3'd1;
	localparam logic [2:0] StPad  = 3'd2;
	localparam logic [2:0] StOut  = 3'd3;
	localparam logic [2:0] StInit = 3'd4;

	logic [2:0]  st_q;
	logic [63:0] len_q;
	logic [5:0]  pos_q;
	logic [1:0]  pad_q;   // 0 none, 1 zero fill, 2 length
	logic        fin_q;   // message end seen: 0x80 still due in StPad, digest due after StCmp
	logic [2:0]  oidx_q;
	logic [2:0]  lidx_q;

	logic        ld_we, start;
	logic [7:0]  ld_byte;
	sha_pkg::cmp_ctl_t ctl;
	sha_pkg::word_t    hash [8];
	logic        acc;

	assign acc = valid_in && ready_in;
	assign ready_in = (st_q == StIdle);

	always_comb begin
		ld_we   = 1'b0;
		ld_byte = data_byte;
		if (st_q == StIdle) begin
			ld_we = acc && has_byte;
		end else if (st_q == StPad) begin
			ld_we = 1'b1;
			if (pad_q == 2'd1) ld_byte = fin_q ? sha_pkg::PadByte : 8'h00;
			else ld_byte = len_q[6'd56 - {lidx_q, 3'b000} +: 8];
		end
	end

	assign start = ld_we && pos_q == 6'd63;

	sha_round u_round (
		.clk(clk), .arst_n(arst_n), .start(start), .ld_we(ld_we),
		.ld_slot(pos_q[5:2]), .ld_byte(ld_byte), .hash_init(st_q == StInit),
		.ctl(ctl), .hash(hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= StIdle;
			len_q  <= '0;
			pos_q  <= '0;
			pad_q  <= '0;
			fin_q  <= 1'b0;
			oidx_q <= '0;
			lidx_q <= '0;
		end else begin
			if (ld_we) pos_q <= pos_q + 6'd1;
			unique case (st_q)
				StIdle: begin
					if (acc) begin
						if (has_byte) len_q <= len_q + 64'd8;
						if (is_last) begin
							fin_q <= 1'b1;
							pad_q <= 2'd1;
						end
						if (start) st_q <= StCmp;
						else if (is_last) st_q <= StPad;
					end
				end
				StCmp: begin
					if (!ctl.busy && !ctl.start) st_q <= (pad_q != 2'd0) ? StPad
						: (fin_q ? StOut : StIdle);
				end
				StPad: begin
					// fin_q still set marks the 0x80 byte, the first pad byte
					if (pad_q == 2'd1) begin
						if (pos_q == 6'd55) begin
							pad_q  <= 2'd2;
							lidx_q <= '0;
						end
						fin_q <= 1'b0;
						if (start) st_q <= StCmp;
					end else begin
						lidx_q <= lidx_q + 3'd1;
						if (lidx_q == 3'd7) begin
							pad_q <= 2'd0;
							fin_q <= 1'b1;
							st_q  <= StCmp;
						end
					end
				end
				StOut: begin
					if (ready_out) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) st_q <= StInit;
					end
				end
				StInit: begin
					len_q <= '0;
					fin_q <= 1'b0;
					st_q  <= StIdle;
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	assign valid_out   = (st_q == StOut);
	assign digest_word = hash[oidx_q];
	assign word_index  = oidx_q;
	assign last_word   = (oidx_q == 3'd7);

	`SHA_ASSERT_IMP(a_rdy_idle, ready_in, st_q == StIdle && !ctl.busy)
	`SHA_ASSERT_IMP(a_out_quiet, valid_out, !ctl.busy && !ld_we)
	`SHA_ASSERT_IMP(a_len_pos, st_q == StPad && pad_q == 2'd2, pos_q[5:3] == 3'd7)
endmodule
